@@ src/kcv_pkg.sv @@
// Shared types, constants and the update microprogram of the range tracker.
`default_nettype none
package kcv_pkg;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam logic [15:0] RST_PERIOD = 16'd6554;
  localparam logic [30:0] RST_QPOS   = 31'd32768;
  localparam logic [30:0] RST_QVEL   = 31'd65536;
  localparam logic [30:0] RST_RNOISE = 31'd131072;

  localparam int STEP_W    = 5;
  localparam int STEP_S    = 13;  // step that forms the gain divisor
  localparam int STEP_LAST = 27;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_QPOS   = 2'd1,
    REG_QVEL   = 2'd2,
    REG_RNOISE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    R_ED, R_EV, R_C00, R_C01, R_C10, R_C11, R_A00, R_A01, R_P00, R_P10,
    R_P11, R_Y, R_S, R_K0, R_K1, R_TMP, R_T, R_QP, R_QV, R_R, R_Z
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t d;
  } uop_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] measured_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] distance_estimate;
    logic signed [31:0] speed_estimate;
    logic              saturated;
  } out_item_t;

  function automatic uop_t prog(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:  u = '{OP_MUL, R_T,   R_EV,  R_TMP};
      5'd1:  u = '{OP_ADD, R_ED,  R_TMP, R_ED};
      5'd2:  u = '{OP_MUL, R_T,   R_C10, R_TMP};
      5'd3:  u = '{OP_ADD, R_C00, R_TMP, R_A00};
      5'd4:  u = '{OP_MUL, R_T,   R_C11, R_TMP};
      5'd5:  u = '{OP_ADD, R_C01, R_TMP, R_A01};
      5'd6:  u = '{OP_MUL, R_T,   R_A01, R_TMP};
      5'd7:  u = '{OP_ADD, R_A00, R_TMP, R_TMP};
      5'd8:  u = '{OP_ADD, R_TMP, R_QP,  R_P00};
      5'd9:  u = '{OP_MUL, R_T,   R_C11, R_TMP};
      5'd10: u = '{OP_ADD, R_C10, R_TMP, R_P10};
      5'd11: u = '{OP_ADD, R_C11, R_QV,  R_P11};
      5'd12: u = '{OP_SUB, R_Z,   R_ED,  R_Y};
      5'd13: u = '{OP_ADD, R_P00, R_R,   R_S};
      5'd14: u = '{OP_DIV, R_P00, R_S,   R_K0};
      5'd15: u = '{OP_DIV, R_P10, R_S,   R_K1};
      5'd16: u = '{OP_MUL, R_K0,  R_Y,   R_TMP};
      5'd17: u = '{OP_ADD, R_ED,  R_TMP, R_ED};
      5'd18: u = '{OP_MUL, R_K1,  R_Y,   R_TMP};
      5'd19: u = '{OP_ADD, R_EV,  R_TMP, R_EV};
      5'd20: u = '{OP_MUL, R_K0,  R_P00, R_TMP};
      5'd21: u = '{OP_SUB, R_P00, R_TMP, R_C00};
      5'd22: u = '{OP_MUL, R_K0,  R_A01, R_TMP};
      5'd23: u = '{OP_SUB, R_A01, R_TMP, R_C01};
      5'd24: u = '{OP_MUL, R_K1,  R_P00, R_TMP};
      5'd25: u = '{OP_SUB, R_P10, R_TMP, R_C10};
      5'd26: u = '{OP_MUL, R_K1,  R_A01, R_TMP};
      5'd27: u = '{OP_SUB, R_P11, R_TMP, R_C11};
      default: u = '{OP_ADD, R_TMP, R_TMP, R_TMP};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

@@ src/kcv_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Kalman gains.
`default_nettype none
module kcv_div #(
  parameter int FRAC_BITS  = kcv_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = kcv_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [DATA_WIDTH-1:0]  num,
  input  wire logic signed [DATA_WIDTH-1:0]  den,
  output logic                               done,
  output logic                               quo_neg,
  output logic [DATA_WIDTH+FRAC_BITS:0]      quo
);
  import kcv_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int QW = DW + FB + 1;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] w_r, q_r;
  logic [DW-1:0] rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          done_r, neg_r;

  logic [DW-1:0] n_mag;
  logic [QW-1:0] w_init;
  logic [DW:0]   rem_sh;
  logic          take;

  assign n_mag  = num[DW-1] ? (~num + 1'b1) : num;
  assign w_init = {1'b0, n_mag, {FB{1'b0}}} + QW'(den[DW-1:1]);
  assign rem_sh = {rem_r, w_r[QW-1]};
  assign take   = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        w_r   <= w_init;
        q_r   <= '0;
        rem_r <= '0;
        d_r   <= den;
        neg_r <= num[DW-1];
        cnt_r <= CW'(QW);
      end else if (cnt_r != '0) begin
        rem_r <= take ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];
        w_r   <= {w_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign quo     = q_r;
  assign quo_neg = neg_r;

endmodule
`default_nettype wire

@@ src/kcv_alu.sv @@
// Shared saturating add, subtract, rounding multiply and quotient finish.
`default_nettype none
module kcv_alu #(
  parameter int FRAC_BITS  = kcv_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = kcv_pkg::DEF_DATA_WIDTH
) (
  input  kcv_pkg::op_t                                     op,
  input  wire logic signed [(DATA_WIDTH > 32 ? DATA_WIDTH : 32):0] a,
  input  wire logic signed [(DATA_WIDTH > 32 ? DATA_WIDTH : 32):0] b,
  input  wire logic [DATA_WIDTH+FRAC_BITS:0]               quo,
  input  wire logic                                        quo_neg,
  output logic signed [DATA_WIDTH-1:0]                     res,
  output logic                                             clip
);
  import kcv_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int EW = (DW > 32 ? DW : 32) + 1;
  localparam int QW = DW + FB + 1;
  localparam int MW = (2 * DW > QW) ? 2 * DW : QW;

  localparam logic signed [EW:0]   SUM_MAX = {{(EW - DW + 2){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [EW:0]   SUM_MIN = ~SUM_MAX;
  localparam logic [DW-1:0]        DMAX    = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0]        DMIN    = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [2*DW-1:0]      ROUND   = (2*DW)'(1) << (FB - 1);

  logic signed [EW:0] sum;
  logic [DW-1:0]      ma, mb;
  logic [2*DW-1:0]    prod, rnd;
  logic [MW-1:0]      mag, lim;
  logic               neg;

  assign ma   = a[DW-1] ? (~a[DW-1:0] + 1'b1) : a[DW-1:0];
  assign mb   = b[DW-1] ? (~b[DW-1:0] + 1'b1) : b[DW-1:0];
  assign prod = (2*DW)'(ma) * (2*DW)'(mb);
  assign rnd  = prod + ROUND;

  always_comb begin
    sum = (op == OP_SUB) ? ({a[EW-1], a} - {b[EW-1], b}) : ({a[EW-1], a} + {b[EW-1], b});
    if (op == OP_DIV) begin
      mag = MW'(quo);
      neg = quo_neg;
    end else begin
      mag = MW'(rnd >> FB);
      neg = a[DW-1] ^ b[DW-1];
    end
    lim = neg ? MW'(DMIN) : MW'(DMAX);
    case (op)
      OP_ADD, OP_SUB: begin
        clip = (sum > SUM_MAX) || (sum < SUM_MIN);
        if (sum > SUM_MAX) begin
          res = DMAX;
        end else if (sum < SUM_MIN) begin
          res = DMIN;
        end else begin
          res = sum[DW-1:0];
        end
      end
      default: begin
        clip = mag > lim;
        if (clip) begin
          res = neg ? DMIN : DMAX;
        end else begin
          res = neg ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
        end
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/kalman_cv_range_tracker.sv @@
// Top level: constant-velocity Kalman range tracker with register port and sequencer.
`default_nettype none
// Two-state (range, range rate) Kalman tracker in signed fixed point, FRAC_BITS
// fraction bits in DATA_WIDTH bits (Q16.16 by default). Each request carries a
// measured range; kind 1 reseeds the track, kind 0 predicts and corrects. One
// request is in work at a time. A reseed goes straight to the output stage; an
// update steps through the microprogram on the single shared multiply/add unit,
// with the bit-serial divider forming the two gains. A result waits in the final
// state until the output is free. A new request is taken while a result still
// waits on the output. Registers: 0x0 sample period, 0x4 position process noise,
// 0x8 speed process noise, 0xC measurement noise.
module kalman_cv_range_tracker #(
  parameter int FRAC_BITS  = kcv_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = kcv_pkg::DEF_DATA_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  kcv_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kcv_pkg::out_item_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import kcv_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int EW = (DW > 32 ? DW : 32) + 1;
  localparam int QW = DW + FB + 1;

  localparam logic signed [EW-1:0] E_MAX = {{(EW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [EW-1:0] E_MIN = ~E_MAX;
  localparam logic signed [EW-1:0] O_MAX = {{(EW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] O_MIN = ~O_MAX;
  localparam logic signed [DW-1:0] ONE   = DW'(1) << FB;

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_DIV, ST_CHK, ST_FIN} state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic                started_r, sat_r, out_valid_r;
  out_item_t           out_data_r;
  logic [15:0]         period_r;
  logic [30:0]         qpos_r, qvel_r, rnoise_r;
  logic signed [DW-1:0] ed_r, ev_r, c00_r, c01_r, c10_r, c11_r;
  logic signed [DW-1:0] a00_r, a01_r, p00_r, p10_r, p11_r, y_r, s_r, k0_r, k1_r;
  logic signed [DW-1:0] tmp_r, z_r;

  uop_t                uop;
  logic signed [EW-1:0] opa, opb;
  logic signed [DW-1:0] alu_res;
  logic                alu_clip;
  logic                div_start, div_done;
  logic [QW-1:0]       quo;
  logic                quo_neg;

  logic                cfg_wr, in_fire, out_free;
  logic signed [EW-1:0] zin, ed_x, ev_x;
  logic                zclip, ed_clip, ev_clip;
  logic signed [DW-1:0] zval;
  logic                wr_en;

  function automatic logic signed [EW-1:0] sx(input logic signed [DW-1:0] v);
    return {{(EW - DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [EW-1:0] opnd(input sel_t s);
    logic signed [EW-1:0] v;
    unique case (s)
      R_ED:  v = sx(ed_r);
      R_EV:  v = sx(ev_r);
      R_C00: v = sx(c00_r);
      R_C01: v = sx(c01_r);
      R_C10: v = sx(c10_r);
      R_C11: v = sx(c11_r);
      R_A00: v = sx(a00_r);
      R_A01: v = sx(a01_r);
      R_P00: v = sx(p00_r);
      R_P10: v = sx(p10_r);
      R_P11: v = sx(p11_r);
      R_Y:   v = sx(y_r);
      R_S:   v = sx(s_r);
      R_K0:  v = sx(k0_r);
      R_K1:  v = sx(k1_r);
      R_TMP: v = sx(tmp_r);
      R_T:   v = {{(EW - 16){1'b0}}, period_r};
      R_QP:  v = {{(EW - 31){1'b0}}, qpos_r};
      R_QV:  v = {{(EW - 31){1'b0}}, qvel_r};
      R_R:   v = {{(EW - 31){1'b0}}, rnoise_r};
      R_Z:   v = sx(z_r);
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop  = prog(step_r);

  always_comb begin
    opa = opnd(uop.a);
    opb = opnd(uop.b);
  end

  kcv_alu #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_alu (
    .op      (uop.op),
    .a       (opa),
    .b       (opb),
    .quo     (quo),
    .quo_neg (quo_neg),
    .res     (alu_res),
    .clip    (alu_clip)
  );

  assign div_start = (state_r == ST_RUN) && (uop.op == OP_DIV);

  kcv_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (opa[DW-1:0]),
    .den     (opb[DW-1:0]),
    .done    (div_done),
    .quo_neg (quo_neg),
    .quo     (quo)
  );

  // measurement into the working format
  assign zin   = {{(EW - 32){in_data.measured_distance[31]}}, in_data.measured_distance};
  assign zclip = (zin > E_MAX) || (zin < E_MIN);
  assign zval  = (zin > E_MAX) ? E_MAX[DW-1:0] :
                 (zin < E_MIN) ? E_MIN[DW-1:0] : zin[DW-1:0];

  assign ed_x    = sx(ed_r);
  assign ev_x    = sx(ev_r);
  assign ed_clip = (ed_x > O_MAX) || (ed_x < O_MIN);
  assign ev_clip = (ev_x > O_MAX) || (ev_x < O_MIN);

  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign wr_en    = ((state_r == ST_RUN) && (uop.op != OP_DIV)) ||
                    ((state_r == ST_DIV) && div_done);

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_PERIOD: prdata = {16'd0, period_r};
      REG_QPOS:   prdata = {1'b0, qpos_r};
      REG_QVEL:   prdata = {1'b0, qvel_r};
      REG_RNOISE: prdata = {1'b0, rnoise_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      started_r   <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= RST_PERIOD;
      qpos_r      <= RST_QPOS;
      qvel_r      <= RST_QVEL;
      rnoise_r    <= RST_RNOISE;
      ed_r        <= '0;
      ev_r        <= '0;
      c00_r       <= ONE;
      c01_r       <= '0;
      c10_r       <= '0;
      c11_r       <= ONE;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[3:2]))
          REG_PERIOD: period_r <= pwdata[15:0];
          REG_QPOS:   qpos_r   <= pwdata[30:0];
          REG_QVEL:   qvel_r   <= pwdata[30:0];
          REG_RNOISE: rnoise_r <= pwdata[30:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        sat_r <= sat_r | alu_clip;
        unique case (uop.d)
          R_ED:  ed_r  <= alu_res;
          R_EV:  ev_r  <= alu_res;
          R_C00: c00_r <= alu_res;
          R_C01: c01_r <= alu_res;
          R_C10: c10_r <= alu_res;
          R_C11: c11_r <= alu_res;
          R_A00: a00_r <= alu_res;
          R_A01: a01_r <= alu_res;
          R_P00: p00_r <= alu_res;
          R_P10: p10_r <= alu_res;
          R_P11: p11_r <= alu_res;
          R_Y:   y_r   <= alu_res;
          R_S:   s_r   <= alu_res;
          R_K0:  k0_r  <= alu_res;
          R_K1:  k1_r  <= alu_res;
          default: tmp_r <= alu_res;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            z_r    <= zval;
            sat_r  <= zclip;
            step_r <= '0;
            if (in_data.kind || !started_r) begin
              ed_r      <= zval;
              ev_r      <= '0;
              c00_r     <= ONE;
              c01_r     <= '0;
              c10_r     <= '0;
              c11_r     <= ONE;
              started_r <= 1'b1;
            end
            state_r <= in_data.kind ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (uop.op == OP_DIV) begin
            state_r <= ST_DIV;
          end else if (step_r == STEP_W'(STEP_S)) begin
            state_r <= ST_CHK;
          end else if (step_r == STEP_W'(STEP_LAST)) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_r  <= step_r + 1'b1;
            state_r <= ST_RUN;
          end
        end
        ST_CHK: begin
          // non-positive divisor: keep the prediction, zero gain
          if (!s_r[DW-1] && (s_r != '0)) begin
            step_r  <= step_r + 1'b1;
            state_r <= ST_RUN;
          end else begin
            c00_r   <= p00_r;
            c01_r   <= a01_r;
            c10_r   <= p10_r;
            c11_r   <= p11_r;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_data_r.distance_estimate <= ed_clip ? (ed_x[EW-1] ? O_MIN[31:0] : O_MAX[31:0])
                                                    : ed_x[31:0];
            out_data_r.speed_estimate    <= ev_clip ? (ev_x[EW-1] ? O_MIN[31:0] : O_MAX[31:0])
                                                    : ev_x[31:0];
            out_data_r.saturated         <= sat_r | ed_clip | ev_clip;
            out_valid_r                  <= 1'b1;
            state_r                      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

endmodule
`default_nettype wire

@@ test/kalman_cv_range_tracker_tb.sv @@
// Testbench for the constant-velocity Kalman range tracker: random and directed requests.
`timescale 1ns / 100ps
module kalman_cv_range_tracker_tb;
  import kcv_pkg::*;

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kalman_cv_range_tracker DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // tracker state mirror
  longint trk_t, trk_qp, trk_qv, trk_r;
  longint trk_x, trk_v, trk_c00, trk_c01, trk_c10, trk_c11;
  bit trk_started;
  bit trk_clip;

  in_item_t pending_requests[$];
  out_item_t expected_estimates[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sender_hold = 1'b0;
  int rx_holdoff = 0;
  bit long_holdoff_req = 1'b0;

  function automatic longint clip(longint v);
    if (v > MAXV) begin
      trk_clip = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      trk_clip = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  // finish a signed magnitude, saturating
  function automatic longint signed_mag(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (m > lim) begin
      trk_clip = 1'b1;
      return neg ? MINV : MAXV;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] m;
    m = 128'(mag(a)) * 128'(mag(b)) + 128'd32768;
    return signed_mag((a < 0) != (b < 0), m >> 16);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    logic [127:0] n;
    n = (128'(mag(num)) << 16) + 128'(den >>> 1);
    return signed_mag(num < 0, n / 128'(den));
  endfunction

  function automatic void seed_track(longint z);
    trk_x = z;
    trk_v = 0;
    trk_c00 = 65536;
    trk_c01 = 0;
    trk_c10 = 0;
    trk_c11 = 65536;
    trk_started = 1'b1;
  endfunction

  function automatic out_item_t track_step(in_item_t it);
    longint z, a00, a01, p00, p01, p10, p11, y, s, k0, k1;
    out_item_t r;
    z = longint'(it.measured_distance);
    trk_clip = 1'b0;
    if (it.kind) begin
      seed_track(z);
    end else begin
      if (!trk_started) seed_track(z);
      trk_x = clip(trk_x + fx_mul(trk_t, trk_v));
      a00 = clip(trk_c00 + fx_mul(trk_t, trk_c10));
      a01 = clip(trk_c01 + fx_mul(trk_t, trk_c11));
      p00 = clip(clip(a00 + fx_mul(trk_t, a01)) + trk_qp);
      p01 = a01;
      p10 = clip(trk_c10 + fx_mul(trk_t, trk_c11));
      p11 = clip(trk_c11 + trk_qv);
      y = clip(z - trk_x);
      s = clip(p00 + trk_r);
      if (s > 0) begin
        k0 = fx_div(p00, s);
        k1 = fx_div(p10, s);
        trk_x = clip(trk_x + fx_mul(k0, y));
        trk_v = clip(trk_v + fx_mul(k1, y));
        trk_c00 = clip(p00 - fx_mul(k0, p00));
        trk_c01 = clip(p01 - fx_mul(k0, p01));
        trk_c10 = clip(p10 - fx_mul(k1, p00));
        trk_c11 = clip(p11 - fx_mul(k1, p01));
      end else begin
        trk_c00 = p00;
        trk_c01 = p01;
        trk_c10 = p10;
        trk_c11 = p11;
      end
    end
    r.distance_estimate = trk_x[31:0];
    r.speed_estimate = trk_v[31:0];
    r.saturated = trk_clip;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_estimates.push_back(track_step(in_data));
        void'(pending_requests.pop_front());
        tx_gap = gap_len();
      end
      if (in_valid && !in_ready) begin
        // hold the request until taken
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0 && !sender_hold) begin
        in_valid <= 1'b1;
        in_data <= pending_requests[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected estimate %p", $time, out_data);
          errors++;
        end else begin
          e = expected_estimates.pop_front();
          if (out_data.distance_estimate !== e.distance_estimate) begin
            $display("%0t: distance exp %0d got %0d", $time, e.distance_estimate,
                     out_data.distance_estimate);
            errors++;
          end
          if (out_data.speed_estimate !== e.speed_estimate) begin
            $display("%0t: speed exp %0d got %0d", $time, e.speed_estimate,
                     out_data.speed_estimate);
            errors++;
          end
          if (out_data.saturated !== e.saturated) begin
            $display("%0t: saturated exp %0b got %0b", $time, e.saturated,
                     out_data.saturated);
            errors++;
          end
        end
      end
      if (long_holdoff_req && rx_holdoff == 0) begin
        rx_holdoff = 3000;
        long_holdoff_req = 1'b0;
      end
      if (rx_holdoff > 0) begin
        rx_holdoff--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 49) == 0) rx_holdoff = $urandom_range(20, 300);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PERIOD: trk_t = val[15:0];
      REG_QPOS:   trk_qp = val[30:0];
      REG_QVEL:   trk_qv = val[30:0];
      default:    trk_r = val[30:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid && expected_estimates.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic in_item_t rand_req(bit wild);
    in_item_t it;
    int k;
    it.kind = ($urandom_range(0, 19) == 0);
    k = $urandom_range(0, 9);
    if (wild || k == 0) it.measured_distance = $urandom;
    else if (k == 1) it.measured_distance = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    else it.measured_distance = 32'($signed($urandom_range(0, 40000000)) - 20000000);
    return it;
  endfunction

  task automatic add_req(bit kind, logic [31:0] z);
    in_item_t it;
    it.kind = kind;
    it.measured_distance = z;
    pending_requests.push_back(it);
  endtask

  initial begin
    trk_t = RST_PERIOD;
    trk_qp = RST_QPOS;
    trk_qv = RST_QVEL;
    trk_r = RST_RNOISE;
    trk_x = 0; trk_v = 0;
    trk_c00 = 65536; trk_c01 = 0; trk_c10 = 0; trk_c11 = 65536;
    trk_started = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: first update seeds, extremes, reinit
    add_req(1'b0, 32'd655360);
    add_req(1'b0, 32'd720896);
    add_req(1'b0, 32'h7FFFFFFF);
    add_req(1'b0, 32'h80000000);
    add_req(1'b1, 32'h80000000);
    add_req(1'b0, 32'h7FFFFFFF);
    add_req(1'b1, 32'h7FFFFFFF);
    add_req(1'b0, 32'h00000000);
    add_req(1'b1, 32'hFFFFFFFF);
    add_req(1'b0, 32'h55555555);
    add_req(1'b0, 32'hAAAAAAAA);
    drain();
    // extremes of registers; big negative covariance drives divisor non-positive
    reg_write(REG_PERIOD, 32'd65535);
    reg_write(REG_QPOS, 32'h7FFFFFFF);
    reg_write(REG_QVEL, 32'h7FFFFFFF);
    reg_write(REG_RNOISE, 32'd1);
    for (int i = 0; i < 12; i++) add_req(i == 0, (i % 2) ? 32'h80000000 : 32'h7FFFFFFF);
    drain();
    reg_write(REG_PERIOD, 32'd1);
    reg_write(REG_QPOS, 32'd0);
    reg_write(REG_QVEL, 32'd0);
    reg_write(REG_RNOISE, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++) add_req(i == 0, $urandom);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_PERIOD, $urandom_range(1, 65535));
      reg_write(REG_QPOS, $urandom_range(0, 1) ? $urandom_range(0, 200000) : {1'b0, 31'($urandom)});
      reg_write(REG_QVEL, $urandom_range(0, 1) ? $urandom_range(0, 200000) : {1'b0, 31'($urandom)});
      reg_write(REG_RNOISE, $urandom_range(0, 1) ? $urandom_range(1, 400000) : {1'b0, 31'($urandom)} | 1);
      if (ph == 2) long_holdoff_req = 1'b1;
      for (int i = 0; i < 150; i++) pending_requests.push_back(rand_req(ph == 5));
      if (ph == 3) begin
        // pause the sender until everything has come back
        wait (pending_requests.size() < 75);
        sender_hold = 1'b1;
        wait (!in_valid && expected_estimates.size() == 0);
        sender_hold = 1'b0;
      end
      drain();
    end
    reg_write(REG_PERIOD, 32'(RST_PERIOD));
    reg_write(REG_QPOS, 32'(RST_QPOS));
    reg_write(REG_QVEL, 32'(RST_QVEL));
    reg_write(REG_RNOISE, 32'(RST_RNOISE));
    for (int i = 0; i < 40; i++) pending_requests.push_back(rand_req(1'b0));
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

@@ kalman_cv_range_tracker.f @@
src/kcv_pkg.sv
src/kcv_div.sv
src/kcv_alu.sv
src/kalman_cv_range_tracker.sv
test/kalman_cv_range_tracker_tb.sv
